// ===== rtl/ostb_pkg.sv =====
// Shared types and constants for the one-shot timer bank.
`default_nettype none
package ostb_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;

  localparam int TIME_W = 32;
  localparam int DUR_W  = 24;
  localparam int EV_W   = 8;
  localparam int KIND_W = 2;

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int RES_W = $clog2(MAX_RESULTS + 1);

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

  typedef struct packed {
    logic [TIME_W-1:0] start;
    logic [DUR_W-1:0]  length;
    logic [EV_W-1:0]   event_code;
  } slot_t;

  typedef struct packed {
    logic wr;     // store a new timer
    logic load;   // take the head entry (rotate a kept timer to the back)
    logic shift;  // take the neighbor's entry
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/one_shot_timer_bank_top.sv =====
// One-shot timer bank: control, time counter, output stage and the row of timer cells.
// Add: one transfer per cycle while idle and output stage is free; result is in the next cycle.
// Tick: advances time, then walks the live timers one by one from the head cell (a step
//   can stall on the output stage), then flushes; a tick on an empty bank only advances time.
// An expiry result is held until the next expiry pushes it to the output stage, or until the flush.
// Reset (rst_n low, synchronous) clears time, timer count and control; cell contents are not cleared.
`default_nettype none
module one_shot_timer_bank_top
  import ostb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [31:0]       in_tdata,   // [23:0] duration, [31:24] event_code
  input  wire logic              in_tuser,   // [0] op
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [7:0]             out_tdata,  // [7:0] event_code_res
  output logic [KIND_W-1:0]      out_tuser,  // [1:0] kind
  output logic                   out_tlast
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [RES_W-1:0]  exp_cnt_r, exp_cnt_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [EV_W-1:0]   pend_ev_r, pend_ev_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [EV_W-1:0]   out_ev_r, out_ev_nxt;
  logic              out_last_r, out_last_nxt;

  slot_t             cells [SLOTS];
  slot_t             new_entry;
  slot_t             head;
  logic [TIME_W-1:0] elapsed;
  logic              expired;
  logic              out_free;
  logic              in_xfer;
  logic              add_wr;
  logic              step_go;

  assign new_entry.start      = time_r;
  assign new_entry.length     = in_tdata[DUR_W-1:0];
  assign new_entry.event_code = in_tdata[DUR_W+EV_W-1:DUR_W];

  assign head     = cells[0];
  assign elapsed  = time_r - head.start;
  assign expired  = (elapsed > {{(TIME_W-DUR_W){1'b0}}, head.length})
                    && (exp_cnt_r < RES_W'(MAX_RESULTS));
  assign out_free = !out_valid_r || out_tready;

  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign add_wr    = in_xfer && (in_tuser == OP_ADD) && (cnt_r != CNT_W'(SLOTS));
  // a second expiry pushes the held one out, so it needs room in the output stage
  assign step_go   = (state_r == ST_WALK) && (!expired || !pend_valid_r || out_free);

  // Cell row: each cell shifts toward the head on a walk step; a kept head
  // re-enters at the back of the live timers.
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    cell_ctl_t ctl;
    slot_t     nbr;
    if (i == SLOTS - 1) begin : g_end
      assign nbr = cells[i];
    end else begin : g_mid
      assign nbr = cells[i+1];
    end
    assign ctl.wr    = add_wr && (cnt_r == CNT_W'(i));
    assign ctl.load  = step_go && !expired && (cnt_r == CNT_W'(i + 1));
    assign ctl.shift = step_go;
    ostb_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_entry  (new_entry),
      .head_entry (head),
      .nbr_entry  (nbr),
      .entry      (cells[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    time_nxt       = time_r;
    cnt_nxt        = cnt_r;
    rem_nxt        = rem_r;
    exp_cnt_nxt    = exp_cnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_ev_nxt    = pend_ev_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_kind_nxt   = out_kind_r;
    out_ev_nxt     = out_ev_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_tuser == OP_ADD) begin
            out_valid_nxt = 1'b1;
            out_ev_nxt    = '0;
            out_last_nxt  = 1'b1;
            if (add_wr) begin
              cnt_nxt      = cnt_r + CNT_W'(1);
              out_kind_nxt = KIND_ADD_OK;
            end else begin
              out_kind_nxt = KIND_ADD_FULL;
            end
          end else begin
            time_nxt    = time_r + TIME_W'(1);
            rem_nxt     = cnt_r;
            exp_cnt_nxt = '0;
            if (cnt_r != '0) begin
              state_nxt = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        if (step_go) begin
          rem_nxt = rem_r - CNT_W'(1);
          if (expired) begin
            cnt_nxt        = cnt_r - CNT_W'(1);
            exp_cnt_nxt    = exp_cnt_r + RES_W'(1);
            pend_valid_nxt = 1'b1;
            pend_ev_nxt    = head.event_code;
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_EXPIRED;
              out_ev_nxt    = pend_ev_r;
              out_last_nxt  = 1'b0;
            end
          end
          if (rem_r == CNT_W'(1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_EXPIRED;
          out_ev_nxt     = pend_ev_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      time_r       <= '0;
      cnt_r        <= '0;
      rem_r        <= '0;
      exp_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      time_r       <= time_nxt;
      cnt_r        <= cnt_nxt;
      rem_r        <= rem_nxt;
      exp_cnt_r    <= exp_cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_ev_r  <= pend_ev_nxt;
    out_kind_r <= out_kind_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_ev_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(SLOTS))
    else $error("timer count exceeds bank size");

  a_rem_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (rem_r <= cnt_r) && (rem_r != '0))
    else $error("walk counter out of step with timer count");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("held expiry left behind after a tick");

  a_exp_cap: assert property (@(posedge clk) disable iff (!rst_n)
    exp_cnt_r <= RES_W'(MAX_RESULTS))
    else $error("too many expiries in one tick");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    add_wr |=> (cnt_r == $past(cnt_r) + CNT_W'(1)) && out_valid_r)
    else $error("accepted add did not store a timer");

endmodule
`default_nettype wire

// ===== rtl/ostb_cell.sv =====
// One timer cell of the chain: holds a timer and moves it along the row.
`default_nettype none
module ostb_cell
  import ostb_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire slot_t     new_entry,
  input  wire slot_t     head_entry,
  input  wire slot_t     nbr_entry,
  output slot_t          entry
);

  slot_t entry_r;
  slot_t entry_nxt;

  always_comb begin
    priority if (ctl.wr) begin
      entry_nxt = new_entry;
    end else if (ctl.load) begin
      entry_nxt = head_entry;
    end else if (ctl.shift) begin
      entry_nxt = nbr_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule
`default_nettype wire
